// ===== rtl/core/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, operation codes and shared types.
// No dependencies.
`default_nettype none
package rau_pkg;
	localparam int OPERAND_WIDTH = 32;
	localparam int KIND_W = 4;
	localparam int FIELD_W = 32;
	localparam int RES_W = 64;
	localparam int CNT_W = 7;

	typedef enum logic [KIND_W-1:0] {
		K_MAKE = 4'd0,
		K_ADD  = 4'd1,
		K_SUB  = 4'd2,
		K_MUL  = 4'd3,
		K_DIV  = 4'd4,
		K_INC  = 4'd5,
		K_DEC  = 4'd6,
		K_EQ   = 4'd7,
		K_NE   = 4'd8
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [FIELD_W-1:0] num_a;
		logic signed [FIELD_W-1:0] den_a;
		logic signed [FIELD_W-1:0] num_b;
		logic signed [FIELD_W-1:0] den_b;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] res_num;
		logic signed [RES_W-1:0] res_den;
		logic                    zero_den_error;
		logic                    compare_true;
	} out_item_t;

	function automatic logic [RES_W-1:0] sext_op(input logic [FIELD_W-1:0] v);
		logic [OPERAND_WIDTH-1:0] t;
		t = v[OPERAND_WIDTH-1:0];
		return {{(RES_W-OPERAND_WIDTH){t[OPERAND_WIDTH-1]}}, t};
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/rau_stream_if.sv =====
// Valid/ready channel interface carrying one payload of type T.
// Does not depend on rau_pkg; the payload type is a parameter.
`default_nettype none
interface rau_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rau_divider.sv =====
// Iterative 64-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
`default_nettype none
module rau_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rau_pkg::RES_W-1:0]  dividend,
	input  wire logic [rau_pkg::RES_W-1:0]  divisor,
	output logic                            done,
	output logic [rau_pkg::RES_W-1:0]       quotient,
	output logic [rau_pkg::RES_W-1:0]       remainder
);
	logic [rau_pkg::RES_W-1:0] d_q;
	logic [rau_pkg::RES_W:0]   r_q;
	logic [rau_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic [rau_pkg::RES_W:0]   shifted;
	logic [rau_pkg::RES_W:0]   diff;

	assign shifted = {r_q[rau_pkg::RES_W-1:0], quotient[rau_pkg::RES_W-1]};
	assign diff = shifted - {1'b0, d_q};
	assign remainder = r_q[rau_pkg::RES_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rau_pkg::CNT_W'(rau_pkg::RES_W - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= divisor;
			r_q <= '0;
			quotient <= dividend;
		end else if (busy_q) begin
			if (!diff[rau_pkg::RES_W]) begin
				r_q <= diff;
				quotient <= {quotient[rau_pkg::RES_W-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				quotient <= {quotient[rau_pkg::RES_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: three cross products, then Euclid GCD and two divisions
// on one shared iterative divider. Inc, dec, eq, ne and unused kinds go straight
// from the products to the output; zero-denominator and zero-numerator results
// skip the divider; reduced results take one divider run per Euclid remainder
// step, then the two divisions. One transaction at a time; input is
// ready again once the result is loaded in the output register. Reset clears the
// sequencer and the output valid.
`default_nettype none
module rational_arithmetic_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	rau_stream_if.sink   in_ch,
	rau_stream_if.source out_ch
);
	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_FORM, S_INIT, S_GCD, S_GWAIT, S_QN,
		S_QNWAIT, S_QD, S_QDWAIT, S_OUT
	} state_t;

	state_t state_q;
	rau_pkg::in_item_t it_q;
	logic [rau_pkg::RES_W-1:0] na, da, nb, db;
	logic [rau_pkg::RES_W-1:0] p1_q, p2_q, p3_q, n_q, d_q, a_q, b_q, g_q, qn_q;
	logic [rau_pkg::RES_W-1:0] mul_a, mul_b, prod;
	logic [rau_pkg::RES_W-1:0] mn, md;
	logic neg_q;
	logic dv_start;
	logic [rau_pkg::RES_W-1:0] dv_num, dv_den, dv_q, dv_r;
	logic dv_done;
	rau_pkg::out_item_t rslt_q;
	rau_pkg::out_item_t res_q;
	logic ovalid_q;

	assign na = rau_pkg::sext_op(it_q.num_a);
	assign da = rau_pkg::sext_op(it_q.den_a);
	assign nb = rau_pkg::sext_op(it_q.num_b);
	assign db = rau_pkg::sext_op(it_q.den_b);

	assign mn = n_q[rau_pkg::RES_W-1] ? -n_q : n_q;
	assign md = d_q[rau_pkg::RES_W-1] ? -d_q : d_q;

	always_comb begin
		mul_a = na;
		mul_b = db;
		unique case (state_q)
			S_MUL1: begin
				unique case (it_q.kind)
					rau_pkg::K_MUL: begin mul_a = na; mul_b = nb; end
					default:        begin mul_a = na; mul_b = db; end
				endcase
			end
			S_MUL3: begin
				mul_a = da;
				mul_b = db;
			end
			default: begin
				unique case (it_q.kind)
					rau_pkg::K_DIV: begin mul_a = da; mul_b = nb; end
					rau_pkg::K_MUL: begin mul_a = da; mul_b = db; end
					default:        begin mul_a = nb; mul_b = da; end
				endcase
			end
		endcase
	end
	assign prod = mul_a[31:0] * mul_b[31:0] +
		((mul_a[63:32] * mul_b[31:0] + mul_a[31:0] * mul_b[63:32]) << 32);

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_num),
		.divisor(dv_den), .done(dv_done), .quotient(dv_q), .remainder(dv_r)
	);

	assign dv_start = (state_q == S_GCD && b_q != '0) || state_q == S_QN || state_q == S_QD;
	assign dv_num = (state_q == S_GCD) ? a_q : (state_q == S_QN) ? mn : md;
	assign dv_den = (state_q == S_GCD) ? b_q : g_q;

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					it_q <= in_ch.data;
					state_q <= S_MUL1;
				end
				S_MUL1: begin p1_q <= prod; state_q <= S_MUL2; end
				S_MUL2: begin p2_q <= prod; state_q <= S_MUL3; end
				S_MUL3: begin p3_q <= prod; state_q <= S_FORM; end
				S_FORM: begin
					unique case (it_q.kind)
						rau_pkg::K_MAKE: begin n_q <= na; d_q <= da; state_q <= S_INIT; end
						rau_pkg::K_ADD: begin
							n_q <= p1_q + p2_q; d_q <= p3_q; state_q <= S_INIT;
						end
						rau_pkg::K_SUB: begin
							n_q <= p1_q - p2_q; d_q <= p3_q; state_q <= S_INIT;
						end
						rau_pkg::K_MUL, rau_pkg::K_DIV: begin
							n_q <= p1_q; d_q <= p2_q; state_q <= S_INIT;
						end
						rau_pkg::K_INC: begin
							rslt_q <= '{na + da, da, da == '0, 1'b0};
							state_q <= S_OUT;
						end
						rau_pkg::K_DEC: begin
							rslt_q <= '{na - da, da, da == '0, 1'b0};
							state_q <= S_OUT;
						end
						rau_pkg::K_EQ: begin
							rslt_q <= '{'0, '0, 1'b0, (na == nb) && (da == db)};
							state_q <= S_OUT;
						end
						rau_pkg::K_NE: begin
							rslt_q <= '{'0, '0, 1'b0, (na != nb) || (da != db)};
							state_q <= S_OUT;
						end
						default: begin rslt_q <= '0; state_q <= S_OUT; end
					endcase
				end
				S_INIT: begin
					a_q <= mn;
					b_q <= md;
					neg_q <= n_q[rau_pkg::RES_W-1] ^ d_q[rau_pkg::RES_W-1];
					state_q <= S_GCD;
				end
				S_GCD: begin
					if (d_q == '0) begin
						rslt_q <= '{n_q, d_q, 1'b1, 1'b0};
						state_q <= S_OUT;
					end else if (n_q == '0) begin
						rslt_q <= '{'0, 64'd1, 1'b0, 1'b0};
						state_q <= S_OUT;
					end else if (b_q == '0) begin
						g_q <= a_q;
						state_q <= S_QN;
					end else begin
						state_q <= S_GWAIT;
					end
				end
				S_GWAIT: if (dv_done) begin
					a_q <= b_q;
					b_q <= dv_r;
					state_q <= S_GCD;
				end
				S_QN: state_q <= S_QNWAIT;
				S_QNWAIT: if (dv_done) begin qn_q <= dv_q; state_q <= S_QD; end
				S_QD: state_q <= S_QDWAIT;
				S_QDWAIT: if (dv_done) begin
					rslt_q <= '{neg_q ? -qn_q : qn_q, dv_q, 1'b0, 1'b0};
					state_q <= S_OUT;
				end
				S_OUT: if (!ovalid_q) begin
					res_q <= rslt_q;
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== dv/rational_arithmetic_unit_tb.sv =====
// Testbench for rational_arithmetic_unit: directed and random fraction operations
// checked against a built-in predictor of the reduced result.
// Depends on rau_pkg, rau_stream_if and the rational_arithmetic_unit RTL.
`default_nettype none
module rational_arithmetic_unit_tb;
	localparam int RANDOM_ITEMS = 1880;
	localparam longint CYCLE_LIMIT = 60_000_000;

	logic clk;
	logic arst_n;
	logic hold_done;
	int   errors = 0;
	int   accepted;
	longint cycles = 0;
	int   send_gap;
	int   recv_gap;
	int   hold_left;

	rau_pkg::in_item_t  pending_q[$];
	rau_pkg::out_item_t expected_q[$];

	rau_stream_if #(.T(rau_pkg::in_item_t))  in_ch();
	rau_stream_if #(.T(rau_pkg::out_item_t)) out_ch();

	rational_arithmetic_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [rau_pkg::RES_W-1:0] abs64(input logic [rau_pkg::RES_W-1:0] v);
		return v[rau_pkg::RES_W-1] ? -v : v;
	endfunction

	function automatic rau_pkg::out_item_t reduce_fraction(
		input logic [rau_pkg::RES_W-1:0] n,
		input logic [rau_pkg::RES_W-1:0] d);
		rau_pkg::out_item_t r;
		logic [rau_pkg::RES_W-1:0] x, y, t, qn;
		r = '0;
		if (d == '0) begin
			r.res_num = n;
			r.res_den = d;
			r.zero_den_error = 1'b1;
		end else if (n == '0) begin
			r.res_den = 64'd1;
		end else begin
			x = abs64(n);
			y = abs64(d);
			while (y != '0) begin
				t = x % y;
				x = y;
				y = t;
			end
			qn = abs64(n) / x;
			r.res_num = (n[rau_pkg::RES_W-1] ^ d[rau_pkg::RES_W-1]) ? -qn : qn;
			r.res_den = abs64(d) / x;
		end
		return r;
	endfunction

	function automatic logic [rau_pkg::RES_W-1:0] sext(input logic [rau_pkg::FIELD_W-1:0] v);
		return {{(rau_pkg::RES_W-rau_pkg::OPERAND_WIDTH){v[rau_pkg::OPERAND_WIDTH-1]}},
			v[rau_pkg::OPERAND_WIDTH-1:0]};
	endfunction

	function automatic rau_pkg::out_item_t predict_fraction(input rau_pkg::in_item_t it);
		rau_pkg::out_item_t r;
		logic [rau_pkg::RES_W-1:0] na, da, nb, db;
		na = sext(it.num_a);
		da = sext(it.den_a);
		nb = sext(it.num_b);
		db = sext(it.den_b);
		r = '0;
		case (it.kind)
			rau_pkg::K_MAKE: r = reduce_fraction(na, da);
			rau_pkg::K_ADD:  r = reduce_fraction(na * db + nb * da, da * db);
			rau_pkg::K_SUB:  r = reduce_fraction(na * db - nb * da, da * db);
			rau_pkg::K_MUL:  r = reduce_fraction(na * nb, da * db);
			rau_pkg::K_DIV:  r = reduce_fraction(na * db, da * nb);
			rau_pkg::K_INC, rau_pkg::K_DEC: begin
				r.res_num = (it.kind == rau_pkg::K_INC) ? na + da : na - da;
				r.res_den = da;
				r.zero_den_error = (da == '0);
			end
			rau_pkg::K_EQ: r.compare_true = (na == nb) && (da == db);
			rau_pkg::K_NE: r.compare_true = (na != nb) || (da != db);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [rau_pkg::FIELD_W-1:0] pick_operand();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return $urandom_range(0, 2000) - 1000;
		if (sel < 65) begin
			case ($urandom_range(0, 5))
				0: return 32'h0;
				1: return 32'h1;
				2: return 32'hFFFF_FFFF;
				3: return 32'h7FFF_FFFF;
				4: return 32'h8000_0001;
				default: return 32'h8000_0000;
			endcase
		end
		return $urandom;
	endfunction

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic add_item(input logic [rau_pkg::KIND_W-1:0] k,
		input logic [rau_pkg::FIELD_W-1:0] na,
		input logic [rau_pkg::FIELD_W-1:0] da, input logic [rau_pkg::FIELD_W-1:0] nb,
		input logic [rau_pkg::FIELD_W-1:0] db);
		rau_pkg::in_item_t it;
		it.kind = k;
		it.num_a = na;
		it.den_a = da;
		it.num_b = nb;
		it.den_b = db;
		pending_q.push_back(it);
	endtask

	// transaction sender and input-side predictor
	always @(posedge clk or negedge arst_n) begin
		rau_pkg::in_item_t nxt;
		logic     v;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
			send_gap    <= 0;
			accepted    <= 0;
		end else begin
			v = in_ch.valid;
			nxt = in_ch.data;
			if (in_ch.valid && in_ch.ready) begin
				expected_q.push_back(predict_fraction(in_ch.data));
				accepted <= accepted + 1;
				v = 1'b0;
			end
			if (!v) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (pending_q.size() > 0) begin
					nxt = pending_q.pop_front();
					v = 1'b1;
					send_gap <= pick_gap();
				end
			end
			in_ch.valid <= v;
			in_ch.data  <= nxt;
		end
	end

	// receiver with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap     <= 0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (!hold_done && accepted >= 300) begin
			hold_done    <= 1'b1;
			hold_left    <= 3000;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap     <= recv_gap - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if (out_ch.valid && out_ch.ready)
				recv_gap <= pick_gap();
		end
	end

	// result checker
	always @(posedge clk) begin
		rau_pkg::out_item_t want;
		rau_pkg::out_item_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction num=%0d den=%0d",
					got.res_num, got.res_den);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.res_num !== want.res_num) begin
					$error("res_num expected %0d actual %0d", want.res_num, got.res_num);
					errors++;
				end
				if (got.res_den !== want.res_den) begin
					$error("res_den expected %0d actual %0d", want.res_den, got.res_den);
					errors++;
				end
				if (got.zero_den_error !== want.zero_den_error) begin
					$error("zero_den_error expected %0b actual %0b",
						want.zero_den_error, got.zero_den_error);
					errors++;
				end
				if (got.compare_true !== want.compare_true) begin
					$error("compare_true expected %0b actual %0b",
						want.compare_true, got.compare_true);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [rau_pkg::KIND_W-1:0] k;
		logic [rau_pkg::FIELD_W-1:0] a, b;
		arst_n = 1'b0;

		add_item(rau_pkg::K_MAKE, 6, 4, 0, 0);
		add_item(rau_pkg::K_MAKE, 0, -5, 0, 0);
		add_item(rau_pkg::K_MAKE, 3, 0, 0, 0);
		add_item(rau_pkg::K_MAKE, -12, -18, 7, 7);
		add_item(rau_pkg::K_ADD, 1, 2, 1, 3);
		add_item(rau_pkg::K_SUB, 1, 2, 1, 2);
		add_item(rau_pkg::K_MUL, -2, 3, 3, 4);
		add_item(rau_pkg::K_DIV, 1, 2, 0, 5);
		add_item(rau_pkg::K_DIV, 3, 7, -6, 14);
		add_item(rau_pkg::K_ADD, 1, 0, 1, 5);
		add_item(rau_pkg::K_INC, 5, 3, 9, 9);
		add_item(rau_pkg::K_DEC, 5, 0, 0, 0);
		add_item(rau_pkg::K_INC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
		add_item(rau_pkg::K_EQ, 4, 6, 4, 6);
		add_item(rau_pkg::K_EQ, 2, 3, 4, 6);
		add_item(rau_pkg::K_NE, 2, 3, 4, 6);
		add_item(rau_pkg::K_NE, -1, 9, -1, 9);
		add_item(4'd9, 1, 2, 3, 4);
		add_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(rau_pkg::K_MUL, 32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF,
			32'h8000_0001);
		add_item(rau_pkg::K_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
		add_item(rau_pkg::K_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000);
		add_item(rau_pkg::K_MAKE, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			k = ($urandom_range(0, 19) == 0) ? rau_pkg::KIND_W'($urandom_range(9, 15))
				: rau_pkg::KIND_W'($urandom_range(0, 8));
			a = pick_operand();
			b = pick_operand();
			if ((k == rau_pkg::K_EQ || k == rau_pkg::K_NE) && $urandom_range(0, 1))
				add_item(k, a, b, a, b);
			else
				add_item(k, a, b, pick_operand(), pick_operand());
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_stream_if.sv
rtl/core/rau_divider.sv
rtl/core/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_tb.sv
